@@ design/rrs_pkg.sv @@
// shared types and codes for the round-robin thread scheduler
`timescale 1ns / 1ps

package rrs_pkg;

	localparam int ID_W            = 4;
	localparam int QLEN_W          = 5;
	localparam int MAX_THREADS_DEF = 16;

	localparam logic [1:0] CMD_ADMIT  = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_NEXT   = 2'd2;
	localparam logic [1:0] CMD_EXIT   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_ABSENT  = 2'd2;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [ID_W-1:0] thread_id;
	} rrs_req_t;

	typedef struct packed {
		logic [ID_W-1:0]   chosen_thread;
		logic              chosen_valid;
		logic [1:0]        status;
		logic [QLEN_W-1:0] queue_length;
	} rrs_rsp_t;

endpackage

@@ design/rrs_stream_if.sv @@
// valid/ready stream interface carrying one payload per beat
`timescale 1ns / 1ps

interface rrs_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ design/round_robin_thread_scheduler.sv @@
// round-robin thread scheduler: ring of slots walked by one sequencer
//
// req carries one command per beat (admit, remove, pick next, mark exited)
// and a 4-bit slot number; rsp returns one beat per command with the slot
// picked, a found flag, a status code and the queue length after the step.
// The links live in two small memories with registered reads; the ring is
// walked one link per cycle.
// Every command ends with a queue length sweep over NSLOT slots, where
// NSLOT is min(MAX_THREADS, 16); before it, pick next walks k links of
// the ring, where k is at most MAX_THREADS.
// One command is in flight at a time; req.ready is high only while the
// sequencer is idle. The result waits in an output register, so the next
// command is taken while rsp is stalled; that command then holds in its
// last step until the register is free.
// Reset empties the ring, clears all marks and the head, and drops any
// pending rsp beat. The link memories need no clearing.
`timescale 1ns / 1ps

module round_robin_thread_scheduler
	import rrs_pkg::*;
#(
	parameter int MAX_THREADS = MAX_THREADS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rrs_stream_if.sink   req,
	rrs_stream_if.source rsp
);

	localparam int IDX_W  = $clog2(MAX_THREADS);
	localparam int STEP_W = $clog2(MAX_THREADS + 1);
	localparam int NSLOT  = (MAX_THREADS < (1 << ID_W)) ? MAX_THREADS : (1 << ID_W);
	localparam int SLOT_W = $clog2(NSLOT);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_PICK     = 4'd2;
	localparam logic [3:0] S_ADM_TAIL = 4'd3;
	localparam logic [3:0] S_ADM_LINK = 4'd4;
	localparam logic [3:0] S_REM_LINK = 4'd5;
	localparam logic [3:0] S_COUNT    = 4'd6;
	localparam logic [3:0] S_DONE     = 4'd7;

	logic [3:0] state_q;

	logic [IDX_W-1:0] link_fwd [MAX_THREADS];
	logic [IDX_W-1:0] link_bwd [MAX_THREADS];
	logic [IDX_W-1:0] fwd_rd_q, bwd_rd_q;
	logic [IDX_W-1:0] fwd_raddr, bwd_raddr;
	logic             fwd_we, bwd_we;
	logic [IDX_W-1:0] fwd_waddr, fwd_wdata, bwd_waddr, bwd_wdata;

	logic [MAX_THREADS-1:0] member_q, exited_q;
	logic [IDX_W-1:0]       head_q;
	logic                   nonempty_q;

	logic [1:0]        cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [IDX_W-1:0]  idx;
	logic              id_ok;
	logic [IDX_W-1:0]  tail_q;
	logic [STEP_W-1:0] steps_q;
	logic [SLOT_W-1:0] slot_q;
	logic [IDX_W-1:0]  slot_idx;
	logic [QLEN_W-1:0] qlen_q;
	logic [ID_W-1:0]   chosen_q;
	logic              found_q;
	logic [1:0]        status_q;

	logic     rsp_valid_q;
	rrs_rsp_t rsp_data_q;
	logic     rsp_load;

	assign idx      = IDX_W'(id_q);
	assign id_ok    = (32'(id_q) < 32'(MAX_THREADS));
	assign slot_idx = IDX_W'(slot_q);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	// link memory ports
	always_comb begin
		fwd_raddr = head_q;
		bwd_raddr = head_q;
		fwd_we    = 1'b0;
		bwd_we    = 1'b0;
		fwd_waddr = idx;
		fwd_wdata = idx;
		bwd_waddr = idx;
		bwd_wdata = idx;
		case (state_q)
			S_DECODE: begin
				if (cmd_q == CMD_REMOVE) begin
					fwd_raddr = idx;
					bwd_raddr = idx;
				end
				if (cmd_q == CMD_ADMIT && id_ok && !member_q[idx] && !nonempty_q) begin
					fwd_we = 1'b1;
					bwd_we = 1'b1;
				end
			end
			S_PICK: begin
				// follow the link just read so the walk goes one slot a cycle
				fwd_raddr = fwd_rd_q;
			end
			S_ADM_TAIL: begin
				fwd_we    = 1'b1;
				fwd_wdata = head_q;
				bwd_we    = 1'b1;
				bwd_wdata = bwd_rd_q;
			end
			S_ADM_LINK: begin
				fwd_we    = 1'b1;
				fwd_waddr = tail_q;
				bwd_we    = 1'b1;
				bwd_waddr = head_q;
			end
			S_REM_LINK: begin
				if (fwd_rd_q != idx) begin
					fwd_we    = 1'b1;
					fwd_waddr = bwd_rd_q;
					fwd_wdata = fwd_rd_q;
					bwd_we    = 1'b1;
					bwd_waddr = fwd_rd_q;
					bwd_wdata = bwd_rd_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fwd_we)
			link_fwd[fwd_waddr] <= fwd_wdata;
		if (bwd_we)
			link_bwd[bwd_waddr] <= bwd_wdata;
		fwd_rd_q <= link_fwd[fwd_raddr];
		bwd_rd_q <= link_bwd[bwd_raddr];
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.data.cmd;
			id_q  <= req.data.thread_id;
		end
		if (rsp_load) begin
			rsp_data_q.chosen_thread <= chosen_q;
			rsp_data_q.chosen_valid  <= found_q;
			rsp_data_q.status        <= status_q;
			rsp_data_q.queue_length  <= qlen_q;
		end
		case (state_q)
			S_DECODE: begin
				chosen_q <= '0;
				found_q  <= 1'b0;
				status_q <= ST_OK;
				steps_q  <= '0;
				slot_q   <= '0;
				qlen_q   <= '0;
				if (cmd_q != CMD_NEXT && !id_ok)
					status_q <= ST_ABSENT;
				else if (cmd_q == CMD_ADMIT && member_q[idx])
					status_q <= ST_PRESENT;
				else if (cmd_q == CMD_REMOVE && (!member_q[idx] || !nonempty_q))
					status_q <= ST_ABSENT;
			end
			S_PICK: begin
				steps_q <= steps_q + STEP_W'(1);
				if (!exited_q[fwd_rd_q]) begin
					chosen_q <= ID_W'(fwd_rd_q);
					found_q  <= 1'b1;
				end
			end
			S_ADM_TAIL:
				tail_q <= bwd_rd_q;
			S_COUNT: begin
				slot_q <= slot_q + SLOT_W'(1);
				// the head counts even when it has exited
				if (member_q[slot_idx] && (!exited_q[slot_idx] || slot_idx == head_q))
					qlen_q <= qlen_q + QLEN_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			member_q    <= '0;
			exited_q    <= '0;
			head_q      <= '0;
			nonempty_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req.valid)
						state_q <= S_DECODE;
				end
				S_DECODE: begin
					state_q <= S_COUNT;
					case (cmd_q)
						CMD_NEXT: begin
							if (nonempty_q)
								state_q <= S_PICK;
						end
						CMD_ADMIT: begin
							if (id_ok && !member_q[idx]) begin
								if (nonempty_q) begin
									state_q <= S_ADM_TAIL;
								end else begin
									head_q       <= idx;
									nonempty_q   <= 1'b1;
									member_q[idx] <= 1'b1;
									exited_q[idx] <= 1'b0;
								end
							end
						end
						CMD_REMOVE: begin
							if (id_ok && member_q[idx] && nonempty_q)
								state_q <= S_REM_LINK;
						end
						CMD_EXIT: begin
							if (id_ok)
								exited_q[idx] <= 1'b1;
						end
						default: begin
						end
					endcase
				end
				S_PICK: begin
					if (!exited_q[fwd_rd_q]) begin
						head_q  <= fwd_rd_q;
						state_q <= S_COUNT;
					end else if (fwd_rd_q == head_q || steps_q >= STEP_W'(MAX_THREADS)) begin
						state_q <= S_COUNT;
					end
				end
				S_ADM_TAIL:
					state_q <= S_ADM_LINK;
				S_ADM_LINK: begin
					member_q[idx] <= 1'b1;
					exited_q[idx] <= 1'b0;
					state_q       <= S_COUNT;
				end
				S_REM_LINK: begin
					member_q[idx] <= 1'b0;
					if (fwd_rd_q == idx) begin
						nonempty_q <= 1'b0;
						head_q     <= '0;
					end else if (head_q == idx) begin
						head_q <= fwd_rd_q;
					end
					state_q <= S_COUNT;
				end
				S_COUNT: begin
					if (slot_q == SLOT_W'(NSLOT - 1))
						state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load)
						state_q <= S_IDLE;
				end
				default:
					state_q <= S_IDLE;
			endcase
		end
	end

	// ring flag tracks membership
	a_nonempty_members: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q == (|member_q))
		else $error("ring flag disagrees with member marks");

	// head is always a member of a non-empty ring
	a_head_member: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q |-> member_q[head_q])
		else $error("head is not a ring member");

	// the walk never runs past the bound
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK) |-> (steps_q <= STEP_W'(MAX_THREADS)))
		else $error("pick walk exceeded slot count");

	// an accepted beat starts decoding in the next cycle
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_DECODE))
		else $error("accepted beat not decoded");

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the round-robin thread scheduler
`timescale 1ns / 1ps

module testbench;
	import rrs_pkg::*;

	localparam int NSLOTS        = MAX_THREADS_DEF;
	localparam int SETTLE_CYCLES = 48;
	localparam int NUM_REPORTED  = 10;
	localparam int HOLD_CYCLES   = 300;

	logic clk;
	logic arst_n;

	rrs_stream_if #(.payload_t(rrs_req_t)) req_if ();
	rrs_stream_if #(.payload_t(rrs_rsp_t)) rsp_if ();

	round_robin_thread_scheduler #(.MAX_THREADS(NSLOTS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// scoreboard copy of the ring
	logic [ID_W-1:0]   ring_next [NSLOTS];
	logic [ID_W-1:0]   ring_prev [NSLOTS];
	logic [NSLOTS-1:0] in_ring;
	logic [NSLOTS-1:0] has_exited;
	logic [ID_W-1:0]   ring_head;
	logic              ring_occupied;

	rrs_rsp_t pending_outcomes [$];
	int       mismatch_count = 0;
	int       send_idle_pct;
	int       recv_idle_pct;
	int       rsp_hold_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(4_000_000);
		$display("testbench failed");
		$finish;
	end

	// head counts always, other members only while not exited
	function automatic logic [QLEN_W-1:0] live_count();
		logic [QLEN_W-1:0] n;
		logic [ID_W-1:0]   cur;
		int                steps;
		if (!ring_occupied) begin
			return '0;
		end
		n = 1;
		cur = ring_next[ring_head];
		for (steps = 0; steps < NSLOTS && cur != ring_head; steps++) begin
			if (!has_exited[cur]) begin
				n++;
			end
			cur = ring_next[cur];
		end
		return n;
	endfunction

	function automatic rrs_rsp_t predict_outcome(input rrs_req_t beat);
		rrs_rsp_t        outcome;
		logic [ID_W-1:0] id;
		logic [ID_W-1:0] cur;
		logic [ID_W-1:0] tail;
		logic [ID_W-1:0] fwd;
		logic [ID_W-1:0] bwd;
		int              steps;
		logic            found;
		outcome = '0;
		outcome.status = ST_OK;
		id = beat.thread_id;
		case (beat.cmd)
			CMD_NEXT: begin
				if (ring_occupied) begin
					cur = ring_next[ring_head];
					steps = 0;
					found = 1'b1;
					// walk past exited slots, giving up once back at the head
					while (has_exited[cur]) begin
						if (cur == ring_head || steps >= NSLOTS) begin
							found = 1'b0;
							break;
						end
						cur = ring_next[cur];
						steps++;
					end
					if (found) begin
						ring_head = cur;
						outcome.chosen_thread = cur;
						outcome.chosen_valid = 1'b1;
					end
				end
			end
			CMD_ADMIT: begin
				if (in_ring[id]) begin
					outcome.status = ST_PRESENT;
				end else begin
					if (!ring_occupied) begin
						ring_head = id;
						ring_next[id] = id;
						ring_prev[id] = id;
						ring_occupied = 1'b1;
					end else begin
						// insert just behind the head
						tail = ring_prev[ring_head];
						ring_next[id] = ring_head;
						ring_prev[id] = tail;
						ring_next[tail] = id;
						ring_prev[ring_head] = id;
					end
					in_ring[id] = 1'b1;
					has_exited[id] = 1'b0;
				end
			end
			CMD_REMOVE: begin
				if (!in_ring[id] || !ring_occupied) begin
					outcome.status = ST_ABSENT;
				end else begin
					fwd = ring_next[id];
					bwd = ring_prev[id];
					if (fwd == id) begin
						ring_occupied = 1'b0;
						ring_head = '0;
					end else begin
						ring_next[bwd] = fwd;
						ring_prev[fwd] = bwd;
						if (ring_head == id) begin
							ring_head = fwd;
						end
					end
					in_ring[id] = 1'b0;
				end
			end
			default: begin
				has_exited[id] = 1'b1;
			end
		endcase
		outcome.queue_length = live_count();
		return outcome;
	endfunction

	task automatic issue_command(input logic [1:0] cmd, input logic [ID_W-1:0] id);
		rrs_req_t beat;
		beat.cmd = cmd;
		beat.thread_id = id;
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= beat;
		do
			@(posedge clk);
		while (!req_if.ready);
		pending_outcomes.push_back(predict_outcome(beat));
	endtask

	task automatic wait_for_outcomes();
		req_if.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_outcomes.size() != 0);
	endtask

	// member_pct biases the choice towards slots already in the ring
	function automatic logic [ID_W-1:0] pick_slot(input int member_pct);
		logic [ID_W-1:0] slot;
		slot = ID_W'($urandom_range(NSLOTS - 1));
		if (in_ring != '0 && $urandom_range(99) < member_pct) begin
			while (!in_ring[slot]) begin
				slot = ID_W'($urandom_range(NSLOTS - 1));
			end
		end
		return slot;
	endfunction

	task automatic test_directed_cases();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		issue_command(CMD_NEXT, 4'd9);       // empty ring
		issue_command(CMD_REMOVE, 4'd5);     // not in ring
		issue_command(CMD_EXIT, 4'd7);       // mark on a slot outside the ring
		issue_command(CMD_ADMIT, 4'd0);
		issue_command(CMD_NEXT, 4'd15);      // head is the only live slot
		issue_command(CMD_EXIT, 4'd0);
		issue_command(CMD_NEXT, 4'd0);       // nothing live, head stays
		issue_command(CMD_ADMIT, 4'd15);
		issue_command(CMD_ADMIT, 4'd7);      // clears the earlier mark
		issue_command(CMD_ADMIT, 4'd15);     // already in ring
		issue_command(CMD_NEXT, 4'd0);
		issue_command(CMD_EXIT, 4'd15);
		issue_command(CMD_NEXT, 4'd3);
		issue_command(CMD_NEXT, 4'd3);
		issue_command(CMD_ADMIT, 4'd10);
		issue_command(CMD_REMOVE, ring_head); // head moves on
		issue_command(CMD_NEXT, 4'd0);
		issue_command(CMD_REMOVE, 4'd7);
		issue_command(CMD_REMOVE, 4'd15);
		issue_command(CMD_REMOVE, 4'd10);
		issue_command(CMD_REMOVE, 4'd0);     // last member empties the ring
		issue_command(CMD_REMOVE, 4'd0);
		issue_command(CMD_NEXT, 4'd0);
		wait_for_outcomes();
	endtask

	// rsp held off while commands keep coming, so the request side stalls
	task automatic test_backpressure();
		int i;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rsp_hold_left <= HOLD_CYCLES;
		for (i = 0; i < 12; i++) begin
			if (i % 3 == 2) begin
				issue_command(CMD_NEXT, 4'd0);
			end else begin
				issue_command(CMD_ADMIT, pick_slot(0));
			end
		end
		wait_for_outcomes();
	endtask

	task automatic test_random_traffic(input int n, input int sidle, input int ridle);
		int i;
		int pick;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				issue_command(CMD_ADMIT, pick_slot(0));
			end else if (pick < 55) begin
				issue_command(CMD_REMOVE, pick_slot(75));
			end else if (pick < 85) begin
				issue_command(CMD_NEXT, ID_W'($urandom_range(NSLOTS - 1)));
			end else begin
				issue_command(CMD_EXIT, pick_slot(80));
			end
		end
		wait_for_outcomes();
	endtask

	initial begin : rsp_hold_counter
		forever begin
			@(posedge clk);
			if (rsp_hold_left > 0) begin
				rsp_hold_left <= rsp_hold_left - 1;
			end
		end
	end

	initial begin : outcome_checker
		rrs_rsp_t want;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				if (pending_outcomes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= NUM_REPORTED) begin
						$display("%0t: unexpected beat %p", $time, rsp_if.data);
					end
				end else begin
					want = pending_outcomes.pop_front();
					if (rsp_if.data.chosen_thread !== want.chosen_thread ||
					    rsp_if.data.chosen_valid !== want.chosen_valid ||
					    rsp_if.data.status !== want.status ||
					    rsp_if.data.queue_length !== want.queue_length) begin
						mismatch_count++;
						if (mismatch_count <= NUM_REPORTED) begin
							$display("%0t: expected thread %0d valid %0d status %0d qlen %0d",
								$time, want.chosen_thread, want.chosen_valid,
								want.status, want.queue_length);
							$display("%0t: actual   thread %0d valid %0d status %0d qlen %0d",
								$time, rsp_if.data.chosen_thread, rsp_if.data.chosen_valid,
								rsp_if.data.status, rsp_if.data.queue_length);
						end
					end
				end
			end
			rsp_if.ready <= (rsp_hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int s;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		for (s = 0; s < NSLOTS; s++) begin
			ring_next[s] = '0;
			ring_prev[s] = '0;
		end
		in_ring = '0;
		has_exited = '0;
		ring_head = '0;
		ring_occupied = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		rsp_hold_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_backpressure();
		test_random_traffic(383, 28, 73);
		test_random_traffic(383, 73, 28);
		test_random_traffic(383, 0, 0);
		recv_idle_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
design/rrs_pkg.sv
design/rrs_stream_if.sv
design/round_robin_thread_scheduler.sv
verif/testbench.sv
